/* hw/rtl/tlea_pkg.sv */
// ----------------------------------------------------------------------------
// tlea_pkg: shared types and constants of the two-level low energy alarm
// Holds per-level state, the flags that pass from one level to the next,
// screen and register codes, and the cadence timings.
// ----------------------------------------------------------------------------
package tlea_pkg;

    // field widths
    localparam int unsigned PCT_W    = 7;
    localparam int unsigned MIN_W    = 6;
    localparam int unsigned SEC_W    = 6;
    localparam int unsigned MS_W     = 32;
    localparam int unsigned CAD_W    = 10;
    localparam int unsigned CFG_AW   = 2;
    localparam int unsigned CFG_DW   = 7;
    localparam int unsigned S_DATA_W = 56;
    localparam int unsigned M_DATA_W = 8;

    // alarm timeout (seconds per minute) and cadence (milliseconds)
    localparam logic [SEC_W-1:0] SEC_PER_MIN = 6'd60;
    localparam logic [CAD_W-1:0] L1_ON_MS    = 10'd100;
    localparam logic [CAD_W-1:0] L1_OFF_MS   = 10'd750;
    localparam logic [CAD_W-1:0] L2_ON_MS    = 10'd250;
    localparam logic [CAD_W-1:0] L2_OFF_MS   = 10'd250;

    // screen request codes
    typedef enum logic [1:0] {
        SCR_NONE  = 2'd0,
        SCR_ALARM = 2'd1,
        SCR_HOME  = 2'd2
    } screen_t;

    // configuration register indexes
    typedef enum logic [CFG_AW-1:0] {
        CFG_LEVEL1_THR = 2'd0,
        CFG_LEVEL2_THR = 2'd1,
        CFG_AUDIBLE    = 2'd2,
        CFG_AUTO_BL    = 2'd3
    } cfg_index_t;

    // state kept for one alarm level
    typedef struct packed {
        logic             active;
        logic             silenced;
        logic [MIN_W-1:0] end_minute;
        logic [SEC_W-1:0] end_second;
        logic [MS_W-1:0]  next_on_time;
        logic [MS_W-1:0]  next_off_time;
        logic             on_taken;
        logic             off_taken;
    } level_state_t;

    // per-poll flags handed from one level evaluation to the next
    typedef struct packed {
        logic    silence;
        screen_t screen;
        logic    backlight;
        logic    consumed;
        logic    buzzer;
    } poll_flags_t;

    // minute advance modulo 60, valid for any 6-bit input
    function automatic logic [MIN_W-1:0] minute_inc(input logic [MIN_W-1:0] m);
        logic [MIN_W:0] sum;
        sum = {1'b0, m} + 7'd1;
        if (sum >= {1'b0, SEC_PER_MIN}) begin
            sum = sum - {1'b0, SEC_PER_MIN};
        end
        return sum[MIN_W-1:0];
    endfunction

endpackage

/* hw/rtl/tlea_level.sv */
// ----------------------------------------------------------------------------
// tlea_level: evaluation of one alarm level for one poll
// Arms, silences and clears the level, and runs its buzzer cadence. Pure
// combinational logic; the caller holds the state registers.
// ----------------------------------------------------------------------------
module tlea_level (
    input  logic                          enable,
    input  logic [tlea_pkg::PCT_W-1:0]    threshold,
    input  logic [tlea_pkg::CAD_W-1:0]    on_ms,
    input  logic [tlea_pkg::CAD_W-1:0]    off_ms,
    input  logic                          audible,
    input  logic                          auto_bl,
    input  logic [tlea_pkg::PCT_W-1:0]    percent_left,
    input  logic [tlea_pkg::MIN_W-1:0]    clock_minute,
    input  logic [tlea_pkg::SEC_W-1:0]    clock_second,
    input  logic [tlea_pkg::MS_W-1:0]     millis_now,
    input  tlea_pkg::level_state_t        state_in,
    input  tlea_pkg::poll_flags_t         flags_in,
    output tlea_pkg::level_state_t        state_out,
    output tlea_pkg::poll_flags_t         flags_out
);

    logic                       sec_wrap;
    logic [tlea_pkg::SEC_W-1:0] arm_second;
    logic [tlea_pkg::MIN_W-1:0] arm_minute;
    logic [tlea_pkg::MS_W-1:0]  on_len;
    logic [tlea_pkg::MS_W-1:0]  off_len;

    // end time 60 s after arming, with second and minute wrap
    assign sec_wrap   = clock_second >= tlea_pkg::SEC_PER_MIN;
    assign arm_second = sec_wrap ? clock_second - tlea_pkg::SEC_PER_MIN : clock_second;
    assign arm_minute = sec_wrap ? tlea_pkg::minute_inc(tlea_pkg::minute_inc(clock_minute))
                                 : tlea_pkg::minute_inc(clock_minute);

    assign on_len  = {{(tlea_pkg::MS_W-tlea_pkg::CAD_W){1'b0}}, on_ms};
    assign off_len = {{(tlea_pkg::MS_W-tlea_pkg::CAD_W){1'b0}}, off_ms};

    // arm / silence / clear, then cadence on the updated state
    always_comb begin
        state_out = state_in;
        flags_out = flags_in;
        if (enable) begin
            if (percent_left <= threshold) begin
                if (!state_in.active) begin
                    state_out.active        = 1'b1;
                    state_out.end_second    = arm_second;
                    state_out.end_minute    = arm_minute;
                    state_out.next_on_time  = '0;
                    state_out.next_off_time = '0;
                    state_out.on_taken      = 1'b0;
                    state_out.off_taken     = 1'b0;
                    flags_out.screen        = tlea_pkg::SCR_ALARM;
                    if (auto_bl) begin
                        flags_out.backlight = 1'b1;
                    end
                end else if (!state_in.silenced) begin
                    if ((clock_minute == state_in.end_minute &&
                         clock_second >= state_in.end_second) || flags_in.silence) begin
                        if (flags_in.silence) begin
                            flags_out.consumed = 1'b1;
                        end
                        flags_out.silence       = 1'b0;
                        state_out.silenced      = 1'b1;
                        state_out.next_on_time  = '0;
                        state_out.next_off_time = '0;
                        flags_out.screen        = tlea_pkg::SCR_HOME;
                    end
                end
            end else begin
                if (state_in.active && !state_in.silenced) begin
                    flags_out.screen = tlea_pkg::SCR_HOME;
                end
                state_out.active   = 1'b0;
                state_out.silenced = 1'b0;
            end

            if (state_out.active) begin
                if (state_out.silenced || !audible) begin
                    flags_out.buzzer = 1'b0;
                end else begin
                    // on edge
                    if (millis_now > state_out.next_on_time) begin
                        if (!state_out.on_taken) begin
                            state_out.on_taken      = 1'b1;
                            state_out.next_off_time = millis_now + on_len;
                            flags_out.buzzer        = 1'b1;
                        end
                    end else begin
                        state_out.on_taken = 1'b0;
                    end
                    // off edge
                    if (millis_now > state_out.next_off_time) begin
                        if (!state_out.off_taken) begin
                            state_out.off_taken    = 1'b1;
                            state_out.next_on_time = millis_now + off_len;
                            flags_out.buzzer       = 1'b0;
                        end
                    end else begin
                        state_out.off_taken = 1'b0;
                    end
                end
            end
        end
    end

endmodule

/* hw/rtl/two_level_low_energy_alarm.sv */
// ----------------------------------------------------------------------------
// two_level_low_energy_alarm: two-level low energy alarm, one poll per request
// Evaluates both alarm levels for each poll and returns buzzer, screen,
// backlight and silence-taken flags.
// ----------------------------------------------------------------------------
// Usage:
//  - s_ channel carries one poll per request: percent, minute, second,
//    millisecond time and the silence request. m_ channel returns one
//    result request per poll, in order.
//  - cfg port writes the two thresholds, audible enable and auto backlight;
//    write only while no poll is in flight.
//  - path: an accepted poll is captured in the input register, evaluated
//    from there, and its result is registered in the result register for m_.
//  - throughput: one poll per cycle while m_tready is high; the level state
//    loop runs from the state registers through the two level evaluators.
//  - receiver stall: the result register holds, the input register takes
//    one more poll, then s_tready drops until the result is taken.
//  - reset (aresetn low, synchronous): both levels inactive, buzzer off,
//    thresholds 0, audible off, auto backlight on, both registers empty.
// ----------------------------------------------------------------------------
module two_level_low_energy_alarm (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write port
    input  logic                            cfg_wr_en,
    input  logic [tlea_pkg::CFG_AW-1:0]     cfg_addr,
    input  logic [tlea_pkg::CFG_DW-1:0]     cfg_wr_data,
    // poll input
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // percent_left[6:0], clock_minute[12:7], clock_second[18:13],
    // millis_now[50:19], silence_request[51], zero[55:52]
    input  logic [tlea_pkg::S_DATA_W-1:0]   s_tdata,
    // result output
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // buzzer_on[0], screen_request[2:1], backlight_request[3],
    // silence_consumed[4], zero[7:5]
    output logic [tlea_pkg::M_DATA_W-1:0]   m_tdata
);

    // configuration registers
    logic [tlea_pkg::PCT_W-1:0] thr1_reg;
    logic [tlea_pkg::PCT_W-1:0] thr2_reg;
    logic                       audible_reg;
    logic                       auto_bl_reg;

    // input register
    logic                       in_vld_reg;
    logic [tlea_pkg::PCT_W-1:0] pct_reg;
    logic [tlea_pkg::MIN_W-1:0] minute_reg;
    logic [tlea_pkg::SEC_W-1:0] second_reg;
    logic [tlea_pkg::MS_W-1:0]  now_reg;
    logic                       silence_reg;

    // level state and buzzer
    tlea_pkg::level_state_t     lvl1_reg;
    tlea_pkg::level_state_t     lvl2_reg;
    tlea_pkg::level_state_t     lvl1_next;
    tlea_pkg::level_state_t     lvl2_next;
    logic                       buzzer_reg;

    // result register
    logic                       out_vld_reg;
    logic                       out_buzzer_reg;
    tlea_pkg::screen_t          out_screen_reg;
    logic                       out_bl_reg;
    logic                       out_consumed_reg;

    tlea_pkg::poll_flags_t      flags_start;
    tlea_pkg::poll_flags_t      flags_mid;
    tlea_pkg::poll_flags_t      flags_end;
    logic                       lvl1_en;
    logic                       lvl2_en;
    logic                       any_sounding;
    logic                       buzzer_next;
    logic                       advance;

    // handshake
    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {3'b000, out_consumed_reg, out_bl_reg, out_screen_reg, out_buzzer_reg};

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr1_reg    <= '0;
            thr2_reg    <= '0;
            audible_reg <= 1'b0;
            auto_bl_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            case (tlea_pkg::cfg_index_t'(cfg_addr))
                tlea_pkg::CFG_LEVEL1_THR: thr1_reg    <= cfg_wr_data;
                tlea_pkg::CFG_LEVEL2_THR: thr2_reg    <= cfg_wr_data;
                tlea_pkg::CFG_AUDIBLE:    audible_reg <= cfg_wr_data[0];
                tlea_pkg::CFG_AUTO_BL:    auto_bl_reg <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            pct_reg     <= s_tdata[6:0];
            minute_reg  <= s_tdata[12:7];
            second_reg  <= s_tdata[18:13];
            now_reg     <= s_tdata[50:19];
            silence_reg <= s_tdata[51];
        end
    end

    // level 1 runs while level 2 is quiet, level 2 while updated level 1 is quiet
    assign lvl1_en = (thr1_reg != '0) && (!lvl2_reg.active || lvl2_reg.silenced);
    assign lvl2_en = (thr2_reg != '0) && (!lvl1_next.active || lvl1_next.silenced);

    always_comb begin
        flags_start           = '0;
        flags_start.silence   = silence_reg;
        flags_start.screen    = tlea_pkg::SCR_NONE;
        flags_start.buzzer    = buzzer_reg;
    end

    tlea_level u_level1 (
        .enable       (lvl1_en),
        .threshold    (thr1_reg),
        .on_ms        (tlea_pkg::L1_ON_MS),
        .off_ms       (tlea_pkg::L1_OFF_MS),
        .audible      (audible_reg),
        .auto_bl      (auto_bl_reg),
        .percent_left (pct_reg),
        .clock_minute (minute_reg),
        .clock_second (second_reg),
        .millis_now   (now_reg),
        .state_in     (lvl1_reg),
        .flags_in     (flags_start),
        .state_out    (lvl1_next),
        .flags_out    (flags_mid)
    );

    tlea_level u_level2 (
        .enable       (lvl2_en),
        .threshold    (thr2_reg),
        .on_ms        (tlea_pkg::L2_ON_MS),
        .off_ms       (tlea_pkg::L2_OFF_MS),
        .audible      (audible_reg),
        .auto_bl      (auto_bl_reg),
        .percent_left (pct_reg),
        .clock_minute (minute_reg),
        .clock_second (second_reg),
        .millis_now   (now_reg),
        .state_in     (lvl2_reg),
        .flags_in     (flags_mid),
        .state_out    (lvl2_next),
        .flags_out    (flags_end)
    );

    // buzzer forced off when nothing sounds
    assign any_sounding = (lvl1_next.active && !lvl1_next.silenced) ||
                          (lvl2_next.active && !lvl2_next.silenced);
    assign buzzer_next  = flags_end.buzzer && any_sounding && audible_reg;

    // state update and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lvl1_reg    <= '0;
            lvl2_reg    <= '0;
            buzzer_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (advance) begin
                lvl1_reg    <= lvl1_next;
                lvl2_reg    <= lvl2_next;
                buzzer_reg  <= buzzer_next;
                out_vld_reg <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_buzzer_reg   <= buzzer_next;
            out_screen_reg   <= flags_end.screen;
            out_bl_reg       <= flags_end.backlight;
            out_consumed_reg <= flags_end.consumed;
        end
    end

    // the two levels never sound at the same time
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(lvl1_reg.active && !lvl1_reg.silenced && lvl2_reg.active && !lvl2_reg.silenced))
    else $error("both alarm levels active and unsilenced");

    // a backlight request only comes with the alarm screen
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_vld_reg && out_bl_reg) |-> (out_screen_reg == tlea_pkg::SCR_ALARM))
    else $error("backlight request without alarm screen");

    // buzzer only sounds while some level is active and unsilenced
    assert property (@(posedge aclk) disable iff (!aresetn)
        buzzer_reg |-> ((lvl1_reg.active && !lvl1_reg.silenced) ||
                        (lvl2_reg.active && !lvl2_reg.silenced)))
    else $error("buzzer on with no sounding level");

    // a poll that cannot advance stays in the input register
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_vld_reg && !advance) |=> (in_vld_reg && $stable(now_reg) && $stable(pct_reg)))
    else $error("stalled poll lost from input register");

endmodule
